// ===== rtl/pcc_pkg.sv =====
package pcc_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_FRAME  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic [2:0] REG_LOWER_PLANE = 3'd0;
  localparam logic [2:0] REG_UPPER_PLANE = 3'd1;
  localparam logic [2:0] REG_AXIS_X      = 3'd2;
  localparam logic [2:0] REG_AXIS_Y      = 3'd3;
  localparam logic [2:0] REG_AXIS_Z      = 3'd4;
  localparam logic [2:0] REG_BIN_SHIFT   = 3'd5;

  typedef struct packed {
    logic [31:0] t;
    logic [1:0]  dir;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // geometry result, aligned with the second pipeline stage
  typedef struct packed {
    logic hit;
    logic in_pore;
    logic up;
  } geom_t;

endpackage

// ===== rtl/pcc_ram.sv =====
module pcc_ram #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 1,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [WIDTH-1:0] wd_q;
  logic             byp_q;

  // write-first behavior toward a read of the same entry in the same cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q  <= mem[rd_addr_i];
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
      wd_q  <= wr_data_i;
    end
  end

  assign rd_data_o = byp_q ? wd_q : rd_q;

endmodule

// ===== rtl/pcc_geom.sv =====
module pcc_geom (
  input  logic               clk_i,
  input  logic               adv_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] prev_x_i,
  input  logic signed [31:0] prev_y_i,
  input  logic signed [31:0] prev_z_i,
  input  logic signed [31:0] lower_i,
  input  logic signed [31:0] upper_i,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic signed [15:0] axis_z_i,
  output pcc_pkg::geom_t     geom_o
);

  logic signed [31:0] zmin, zmax;
  logic               hit, in_pore;
  logic               hit_a_q, inside_a_q, hit_b_q, inside_b_q;
  logic signed [32:0] dx_q, dy_q, dz_q;
  logic signed [48:0] px_q, py_q, pz_q;
  logic signed [50:0] dot;

  always_comb begin
    zmin    = (pos_z_i < prev_z_i) ? pos_z_i : prev_z_i;
    zmax    = (pos_z_i < prev_z_i) ? prev_z_i : pos_z_i;
    hit     = (zmin < lower_i && lower_i < zmax) || (zmin < upper_i && upper_i < zmax);
    in_pore = (lower_i < pos_z_i) && (pos_z_i < upper_i);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      hit_a_q    <= hit;
      inside_a_q <= in_pore;
      dx_q       <= 33'(pos_x_i) - 33'(prev_x_i);
      dy_q       <= 33'(pos_y_i) - 33'(prev_y_i);
      dz_q       <= 33'(pos_z_i) - 33'(prev_z_i);
      hit_b_q    <= hit_a_q;
      inside_b_q <= inside_a_q;
      px_q       <= 49'(dx_q) * 49'(axis_x_i);
      py_q       <= 49'(dy_q) * 49'(axis_y_i);
      pz_q       <= 49'(dz_q) * 49'(axis_z_i);
    end
  end

  assign dot = 51'(px_q) + 51'(py_q) + 51'(pz_q);

  assign geom_o.hit     = hit_b_q;
  assign geom_o.in_pore = inside_b_q;
  assign geom_o.up      = (dot > 51'sd0);

endmodule

// ===== rtl/pore_crossing_counter_unit.sv =====
// Channel  | Signals                          | Direction
// in       | in_valid_i / in_stall_o  + fields | request into block
// out      | out_valid_o / out_stall_i + fields| result out of block
// cfg      | cfg_valid_i / cfg_ready_o, index, data | register writes
//
// One item per cycle while in_stall_o is low.
// Pipeline: plane test, axis products, entry table update, histogram update.
// After reset a clearing pass over max(MOLECULES, HIST_BINS) entries zeroes
// the tables; in_stall_o is high during it, configuration writes are taken.
// A stalled output stalls the whole pipeline and raises in_stall_o.
module pore_crossing_counter_unit #(
  parameter int unsigned MOLECULES = 4096,
  parameter int unsigned HIST_BINS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  in_command_i,
  input  logic [11:0] in_molecule_i,
  input  logic [31:0] in_sample_time_i,
  input  logic signed [31:0] in_pos_x_i,
  input  logic signed [31:0] in_pos_y_i,
  input  logic signed [31:0] in_pos_z_i,
  input  logic signed [31:0] in_prev_x_i,
  input  logic signed [31:0] in_prev_y_i,
  input  logic signed [31:0] in_prev_z_i,
  input  logic [9:0]  in_bin_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_crossed_o,
  output logic [11:0] out_crossed_molecule_o,
  output logic [31:0] out_residence_time_o,
  output logic [31:0] out_residency_count_o,
  output logic [31:0] out_crossing_count_o,
  output logic [15:0] out_frame_up_o,
  output logic [15:0] out_frame_down_o,
  output logic [47:0] out_frame_time_sum_o,
  output logic [31:0] out_total_up_o,
  output logic [31:0] out_total_down_o,
  output logic [62:0] out_total_time_sum_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned MW  = (MOLECULES > 1) ? $clog2(MOLECULES) : 1;
  localparam int unsigned HW  = $clog2(HIST_BINS);
  localparam int unsigned CLR = (MOLECULES > HIST_BINS) ? MOLECULES : HIST_BINS;
  localparam int unsigned CW  = $clog2(CLR);

  // configuration
  logic signed [31:0] lower_q, upper_q;
  logic signed [15:0] ax_q, ay_q, az_q;
  logic [4:0]         shift_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= 32'sd0;
      upper_q <= 32'sd65536;
      ax_q    <= 16'sd0;
      ay_q    <= 16'sd0;
      az_q    <= 16'sd16384;
      shift_q <= 5'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pcc_pkg::REG_LOWER_PLANE: lower_q <= cfg_data_i;
        pcc_pkg::REG_UPPER_PLANE: upper_q <= cfg_data_i;
        pcc_pkg::REG_AXIS_X:      ax_q    <= cfg_data_i[15:0];
        pcc_pkg::REG_AXIS_Y:      ay_q    <= cfg_data_i[15:0];
        pcc_pkg::REG_AXIS_Z:      az_q    <= cfg_data_i[15:0];
        pcc_pkg::REG_BIN_SHIFT:   shift_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // clearing pass
  logic          clr_act_q;
  logic [CW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_act_q <= 1'b1;
      clr_q     <= '0;
    end else if (clr_act_q) begin
      if (clr_q == CW'(CLR - 1)) begin
        clr_act_q <= 1'b0;
      end else begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  logic adv, accept;
  logic out_valid_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv || clr_act_q;
  assign accept     = in_valid_i && !in_stall_o;

  // stage registers
  logic v1_q, v2_q, v3_q, v4_q;
  pcc_pkg::cmd_e cmd1_q, cmd2_q, cmd3_q, cmd4_q;
  logic [11:0] mol1_q, mol2_q, mol3_q, mol4_q;
  logic sam1_q, sam2_q, sam3_q;
  logic [31:0] t1_q, t2_q, t3_q;
  logic [9:0] bin1_q, bin2_q, bin3_q;
  pcc_pkg::entry_t ent2_q, ent3_q;
  logic in3_q, up3_q;
  logic exit4_q, cross4_q, up4_q, rdok4_q;
  logic [31:0] tau4_q;
  logic [HW-1:0] haddr4_q;

  pcc_pkg::geom_t geom;

  pcc_geom u_geom (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .pos_x_i  (in_pos_x_i),
    .pos_y_i  (in_pos_y_i),
    .pos_z_i  (in_pos_z_i),
    .prev_x_i (in_prev_x_i),
    .prev_y_i (in_prev_y_i),
    .prev_z_i (in_prev_z_i),
    .lower_i  (lower_q),
    .upper_i  (upper_q),
    .axis_x_i (ax_q),
    .axis_y_i (ay_q),
    .axis_z_i (az_q),
    .geom_o   (geom)
  );

  // entry table
  pcc_pkg::entry_t ent_rd, ent_wdata, ewr_data, ent1_fwd, ent2_fwd;
  logic            ewr, ent_we;
  logic [MW-1:0]   ent_waddr;
  logic [1:0]      dir3;

  assign dir3     = up3_q ? pcc_pkg::DIR_UP : pcc_pkg::DIR_DOWN;
  assign ewr      = v3_q && sam3_q && adv;
  assign ewr_data = in3_q ? pcc_pkg::entry_t'{t: t3_q, dir: dir3}
                          : pcc_pkg::entry_t'{t: 32'd0, dir: pcc_pkg::DIR_NONE};

  assign ent_we    = clr_act_q ? (32'(clr_q) < MOLECULES) : ewr;
  assign ent_waddr = clr_act_q ? MW'(clr_q) : MW'(mol3_q);
  assign ent_wdata = clr_act_q ? '0 : ewr_data;

  pcc_ram #(.DEPTH(MOLECULES), .WIDTH(pcc_pkg::EntryW)) u_entry (
    .clk_i     (clk_i),
    .rd_en_i   (adv),
    .rd_addr_i (MW'(in_molecule_i)),
    .wr_en_i   (ent_we),
    .wr_addr_i (ent_waddr),
    .wr_data_i (ent_wdata),
    .rd_data_o (ent_rd)
  );

  // items still in flight see the write of the entry stage
  assign ent1_fwd = (ewr && mol3_q == mol1_q) ? ewr_data : ent_rd;
  assign ent2_fwd = (ewr && mol3_q == mol2_q) ? ewr_data : ent2_q;

  // residence time and bin
  logic [31:0]   tau3, shifted3;
  logic [HW-1:0] hb3, haddr3;
  logic          exit3, cross3;

  always_comb begin
    tau3     = t3_q - ent3_q.t;
    shifted3 = tau3 >> shift_q;
    hb3      = (shifted3 > 32'(HIST_BINS - 1)) ? HW'(HIST_BINS - 1) : HW'(shifted3);
    haddr3   = (cmd3_q == pcc_pkg::CMD_READ) ? HW'(bin3_q) : hb3;
    exit3    = sam3_q && !in3_q;
    cross3   = exit3 && (dir3 == ent3_q.dir);
  end

  // histograms
  logic [31:0]   rh, ch, rh_inc, ch_inc;
  logic          rh_we, ch_we;
  logic [HW-1:0] h_waddr;

  assign rh_inc  = (rh == 32'hFFFF_FFFF) ? rh : rh + 32'd1;
  assign ch_inc  = (ch == 32'hFFFF_FFFF) ? ch : ch + 32'd1;
  assign h_waddr = clr_act_q ? HW'(clr_q) : haddr4_q;
  assign rh_we   = clr_act_q ? (32'(clr_q) < HIST_BINS) : (v4_q && exit4_q && adv);
  assign ch_we   = clr_act_q ? (32'(clr_q) < HIST_BINS) : (v4_q && cross4_q && adv);

  pcc_ram #(.DEPTH(HIST_BINS), .WIDTH(32)) u_res_hist (
    .clk_i     (clk_i),
    .rd_en_i   (adv),
    .rd_addr_i (haddr3),
    .wr_en_i   (rh_we),
    .wr_addr_i (h_waddr),
    .wr_data_i (clr_act_q ? 32'd0 : rh_inc),
    .rd_data_o (rh)
  );

  pcc_ram #(.DEPTH(HIST_BINS), .WIDTH(32)) u_cross_hist (
    .clk_i     (clk_i),
    .rd_en_i   (adv),
    .rd_addr_i (haddr3),
    .wr_en_i   (ch_we),
    .wr_addr_i (h_waddr),
    .wr_data_i (clr_act_q ? 32'd0 : ch_inc),
    .rd_data_o (ch)
  );

  // pipeline advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd1_q  <= pcc_pkg::cmd_e'(in_command_i);
      mol1_q  <= in_molecule_i;
      sam1_q  <= (in_command_i == pcc_pkg::CMD_SAMPLE) && (32'(in_molecule_i) < MOLECULES);
      t1_q    <= in_sample_time_i;
      bin1_q  <= in_bin_index_i;

      cmd2_q  <= cmd1_q;
      mol2_q  <= mol1_q;
      sam2_q  <= sam1_q;
      t2_q    <= t1_q;
      bin2_q  <= bin1_q;
      ent2_q  <= ent1_fwd;

      cmd3_q  <= cmd2_q;
      mol3_q  <= mol2_q;
      sam3_q  <= sam2_q && geom.hit;
      in3_q   <= geom.in_pore;
      up3_q   <= geom.up;
      t3_q    <= t2_q;
      bin3_q  <= bin2_q;
      ent3_q  <= ent2_fwd;

      cmd4_q   <= cmd3_q;
      mol4_q   <= mol3_q;
      exit4_q  <= exit3;
      cross4_q <= cross3;
      up4_q    <= up3_q;
      tau4_q   <= tau3;
      rdok4_q  <= 32'(bin3_q) < HIST_BINS;
      haddr4_q <= haddr3;
    end
  end

  // frame counters and totals
  logic [15:0] fup_q, fdown_q, fup_a, fdown_a;
  logic [47:0] fsum_q, fsum_a;
  logic [31:0] tup_q, tdown_q;
  logic [62:0] tsum_q;
  logic [48:0] fsum_add;
  logic [32:0] tup_add, tdown_add;
  logic [63:0] tsum_add;
  logic [31:0] tup_n, tdown_n;
  logic [62:0] tsum_n;
  logic        is_frame;

  always_comb begin
    fup_a     = (cross4_q && up4_q && fup_q != 16'hFFFF) ? fup_q + 16'd1 : fup_q;
    fdown_a   = (cross4_q && !up4_q && fdown_q != 16'hFFFF) ? fdown_q + 16'd1 : fdown_q;
    fsum_add  = {1'b0, fsum_q} + 49'(tau4_q);
    fsum_a    = !cross4_q ? fsum_q : (fsum_add[48] ? '1 : fsum_add[47:0]);
    tup_add   = {1'b0, tup_q} + 33'(fup_a);
    tdown_add = {1'b0, tdown_q} + 33'(fdown_a);
    tsum_add  = {1'b0, tsum_q} + 64'(fsum_a);
    tup_n     = tup_add[32] ? '1 : tup_add[31:0];
    tdown_n   = tdown_add[32] ? '1 : tdown_add[31:0];
    tsum_n    = tsum_add[63] ? '1 : tsum_add[62:0];
    is_frame  = (cmd4_q == pcc_pkg::CMD_FRAME);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fup_q   <= '0;
      fdown_q <= '0;
      fsum_q  <= '0;
      tup_q   <= '0;
      tdown_q <= '0;
      tsum_q  <= '0;
    end else if (adv && v4_q) begin
      if (is_frame) begin
        fup_q   <= '0;
        fdown_q <= '0;
        fsum_q  <= '0;
        tup_q   <= tup_n;
        tdown_q <= tdown_n;
        tsum_q  <= tsum_n;
      end else begin
        fup_q   <= fup_a;
        fdown_q <= fdown_a;
        fsum_q  <= fsum_a;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_crossed_o          <= cross4_q;
      out_crossed_molecule_o <= cross4_q ? mol4_q : 12'd0;
      out_residence_time_o   <= exit4_q ? tau4_q : 32'd0;
      out_residency_count_o  <= (cmd4_q == pcc_pkg::CMD_READ && rdok4_q) ? rh : 32'd0;
      out_crossing_count_o   <= (cmd4_q == pcc_pkg::CMD_READ && rdok4_q) ? ch : 32'd0;
      out_frame_up_o         <= fup_a;
      out_frame_down_o       <= fdown_a;
      out_frame_time_sum_o   <= fsum_a;
      out_total_up_o         <= is_frame ? tup_n : tup_q;
      out_total_down_o       <= is_frame ? tdown_n : tdown_q;
      out_total_time_sum_o   <= is_frame ? tsum_n : tsum_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== tb/sv/pore_crossing_counter_unit_tb.sv =====
`timescale 1ns / 100ps

module pore_crossing_counter_unit_tb;

  localparam int unsigned MOLECULES = 4096;
  localparam int unsigned HIST_BINS = 1024;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct {
    logic [1:0]         cmd;
    logic [11:0]        mol;
    logic [31:0]        t;
    logic signed [31:0] px, py, pz, qx, qy, qz;
    logic [9:0]         bin;
  } sample_req_t;

  typedef struct {
    logic        crossed;
    logic [11:0] cmol;
    logic [31:0] res_time, res_count, cross_count;
    logic [15:0] fup, fdown;
    logic [47:0] fsum;
    logic [31:0] tup, tdown;
    logic [62:0] tsum;
  } count_rsp_t;

  typedef struct {
    sample_req_t r;
    bit          lit;
    count_rsp_t  e;
  } table_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] in_command_i = '0;
  logic [11:0] in_molecule_i = '0;
  logic [31:0] in_sample_time_i = '0;
  logic signed [31:0] in_pos_x_i = '0, in_pos_y_i = '0, in_pos_z_i = '0;
  logic signed [31:0] in_prev_x_i = '0, in_prev_y_i = '0, in_prev_z_i = '0;
  logic [9:0] in_bin_index_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic out_crossed_o;
  logic [11:0] out_crossed_molecule_o;
  logic [31:0] out_residence_time_o, out_residency_count_o, out_crossing_count_o;
  logic [15:0] out_frame_up_o, out_frame_down_o;
  logic [47:0] out_frame_time_sum_o;
  logic [31:0] out_total_up_o, out_total_down_o;
  logic [62:0] out_total_time_sum_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  always #2 clk_i = ~clk_i;

  pore_crossing_counter_unit #(
    .MOLECULES(MOLECULES),
    .HIST_BINS(HIST_BINS)
  ) i_dut (.*);

  // predictor state
  logic signed [31:0] lower_q, upper_q;
  logic signed [15:0] ax_q, ay_q, az_q;
  logic [4:0]         shift_q;
  logic [31:0] entry_t_q [MOLECULES];
  logic [1:0]  entry_dir_q [MOLECULES];
  logic [31:0] res_hist_q [HIST_BINS];
  logic [31:0] cross_hist_q [HIST_BINS];
  logic [15:0] fup_q, fdown_q;
  logic [47:0] fsum_q;
  logic [31:0] tup_q, tdown_q;
  logic [62:0] tsum_q;

  count_rsp_t expected_counts[$];
  int unsigned mismatches = 0;
  bit idle_on = 1'b1;
  bit hold_go = 1'b0;
  int unsigned out_wait = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  logic [31:0] clock_ticks = 0;

  function automatic count_rsp_t predict_counts(sample_req_t r);
    count_rsp_t o;
    longint z1, z2, pz, qz, zmin, zmax, dot;
    logic [1:0] dir;
    logic [31:0] tau;
    logic [63:0] s;
    int unsigned b;
    o = '{default: '0};
    if (r.cmd == pcc_pkg::CMD_SAMPLE) begin
      z1 = lower_q; z2 = upper_q; pz = r.pz; qz = r.qz;
      zmin = pz < qz ? pz : qz;
      zmax = pz < qz ? qz : pz;
      if ((zmin < z1 && z1 < zmax) || (zmin < z2 && z2 < zmax)) begin
        dot = (longint'(r.px) - longint'(r.qx)) * longint'(ax_q)
            + (longint'(r.py) - longint'(r.qy)) * longint'(ay_q)
            + (pz - qz) * longint'(az_q);
        dir = dot > 0 ? pcc_pkg::DIR_UP : pcc_pkg::DIR_DOWN;
        if (z1 < pz && pz < z2) begin
          entry_t_q[r.mol] = r.t;
          entry_dir_q[r.mol] = dir;
        end else begin
          tau = r.t - entry_t_q[r.mol];
          b = tau >> shift_q;
          if (b > HIST_BINS - 1) b = HIST_BINS - 1;
          o.res_time = tau;
          if (dir == entry_dir_q[r.mol]) begin
            s = 64'(fsum_q) + 64'(tau);
            fsum_q = s > 64'hFFFF_FFFF_FFFF ? 48'hFFFF_FFFF_FFFF : s[47:0];
            if (dir == pcc_pkg::DIR_UP) begin
              if (fup_q != 16'hFFFF) fup_q++;
            end else if (fdown_q != 16'hFFFF) begin
              fdown_q++;
            end
            if (cross_hist_q[b] != 32'hFFFF_FFFF) cross_hist_q[b]++;
            o.crossed = 1'b1;
            o.cmol = r.mol;
          end
          if (res_hist_q[b] != 32'hFFFF_FFFF) res_hist_q[b]++;
          entry_t_q[r.mol] = '0;
          entry_dir_q[r.mol] = pcc_pkg::DIR_NONE;
        end
      end
    end
    o.fup = fup_q; o.fdown = fdown_q; o.fsum = fsum_q;
    if (r.cmd == pcc_pkg::CMD_FRAME) begin
      s = 64'(tup_q) + 64'(fup_q);
      tup_q = s > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : s[31:0];
      s = 64'(tdown_q) + 64'(fdown_q);
      tdown_q = s > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : s[31:0];
      s = 64'(tsum_q) + 64'(fsum_q);
      tsum_q = s > 64'h7FFF_FFFF_FFFF_FFFF ? 63'h7FFF_FFFF_FFFF_FFFF : s[62:0];
      fup_q = '0; fdown_q = '0; fsum_q = '0;
    end else if (r.cmd == pcc_pkg::CMD_READ) begin
      if (r.bin < HIST_BINS) begin
        o.res_count = res_hist_q[r.bin];
        o.cross_count = cross_hist_q[r.bin];
      end
    end
    o.tup = tup_q; o.tdown = tdown_q; o.tsum = tsum_q;
    return o;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      pcc_pkg::REG_LOWER_PLANE: lower_q = val;
      pcc_pkg::REG_UPPER_PLANE: upper_q = val;
      pcc_pkg::REG_AXIS_X:      ax_q = val[15:0];
      pcc_pkg::REG_AXIS_Y:      ay_q = val[15:0];
      pcc_pkg::REG_AXIS_Z:      az_q = val[15:0];
      pcc_pkg::REG_BIN_SHIFT:   shift_q = val[4:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_geometry(int lo, int hi, int ax, int ay, int az, int sh);
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    write_reg(pcc_pkg::REG_LOWER_PLANE, lo);
    write_reg(pcc_pkg::REG_UPPER_PLANE, hi);
    write_reg(pcc_pkg::REG_AXIS_X, ax);
    write_reg(pcc_pkg::REG_AXIS_Y, ay);
    write_reg(pcc_pkg::REG_AXIS_Z, az);
    write_reg(pcc_pkg::REG_BIN_SHIFT, sh);
  endtask

  // called right after a falling edge; returns at the falling edge after accept
  task automatic send_sample(sample_req_t r, bit lit, count_rsp_t e);
    int unsigned gap;
    count_rsp_t p;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_command_i = r.cmd; in_molecule_i = r.mol; in_sample_time_i = r.t;
    in_pos_x_i = r.px; in_pos_y_i = r.py; in_pos_z_i = r.pz;
    in_prev_x_i = r.qx; in_prev_y_i = r.qy; in_prev_z_i = r.qz;
    in_bin_index_i = r.bin;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    p = predict_counts(r);
    expected_counts.push_back(lit ? e : p);
    @(negedge clk_i);
  endtask

  function automatic sample_req_t mk_req(logic [1:0] cmd, logic [11:0] mol, logic [31:0] t,
                                         logic [31:0] pz, logic [31:0] qz, logic [9:0] bin);
    sample_req_t r;
    r = '{default: '0};
    r.cmd = cmd; r.mol = mol; r.t = t; r.pz = pz; r.qz = qz; r.bin = bin;
    return r;
  endfunction

  task automatic send_random(int unsigned n);
    int unsigned sent, k;
    longint lo, hi, zin, zout_lo, zout_hi;
    sample_req_t r;
    count_rsp_t nil;
    bit ok, from_below;
    nil = '{default: '0};
    sent = 0;
    lo = lower_q; hi = upper_q;
    ok = (hi - lo > 4) && lo > -64'sd2147470000 && hi < 64'sd2147470000;
    while (sent < n) begin
      k = $urandom_range(0, 99);
      r = '{default: '0};
      if (k < 60 && ok) begin
        // entry then exit of one molecule
        r.mol = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095))
                                            : 12'($urandom_range(0, 31));
        from_below = 1'($urandom_range(0, 1));
        zin = lo + 1 + ($urandom() % (hi - lo - 1));
        zout_lo = lo - $urandom_range(1, 4000);
        zout_hi = hi + $urandom_range(1, 4000);
        if ($urandom_range(0, 3) == 0) begin
          r.qx = $urandom_range(0, 2000) - 1000; r.qy = $urandom_range(0, 2000) - 1000;
        end
        clock_ticks += $urandom_range(0, 40);
        r.cmd = pcc_pkg::CMD_SAMPLE; r.t = clock_ticks;
        r.qz = from_below ? 32'(zout_lo) : 32'(zout_hi);
        r.pz = 32'(zin);
        send_sample(r, 1'b0, nil);
        clock_ticks += $urandom_range(0, 200);
        r.t = clock_ticks;
        r.qz = 32'(zin);
        // mostly continue through, sometimes turn back
        r.pz = (($urandom_range(0, 3) != 0) == from_below) ? 32'(zout_hi) : 32'(zout_lo);
        send_sample(r, 1'b0, nil);
        sent += 2;
      end else begin
        if (k < 70) r.cmd = pcc_pkg::CMD_FRAME;
        else if (k < 80) begin
          r.cmd = pcc_pkg::CMD_READ;
          r.bin = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                              : 10'($urandom_range(0, 63));
        end else if (k < 85) r.cmd = pcc_pkg::CMD_NOP;
        else begin
          r.cmd = 2'($urandom_range(0, 3)); r.mol = 12'($urandom()); r.t = $urandom();
          r.px = $urandom(); r.py = $urandom(); r.pz = $urandom();
          r.qx = $urandom(); r.qy = $urandom(); r.qz = $urandom();
          r.bin = 10'($urandom());
        end
        send_sample(r, 1'b0, nil);
        sent++;
      end
    end
  endtask

  // receiver: stall pattern on the falling edge
  always @(negedge clk_i) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else if (out_wait > 0) begin
      out_stall_i = 1'b1;
      out_wait--;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t %s: expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    count_rsp_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_counts.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none actual crossed=%0b res=%0h",
                 $time, out_crossed_o, out_residence_time_o);
      end else begin
        e = expected_counts.pop_front();
        check_field("crossed", e.crossed, out_crossed_o);
        check_field("crossed_molecule", e.cmol, out_crossed_molecule_o);
        check_field("residence_time", e.res_time, out_residence_time_o);
        check_field("residency_count", e.res_count, out_residency_count_o);
        check_field("crossing_count", e.cross_count, out_crossing_count_o);
        check_field("frame_up", e.fup, out_frame_up_o);
        check_field("frame_down", e.fdown, out_frame_down_o);
        check_field("frame_time_sum", e.fsum, out_frame_time_sum_o);
        check_field("total_up", e.tup, out_total_up_o);
        check_field("total_down", e.tdown, out_total_down_o);
        check_field("total_time_sum", e.tsum, out_total_time_sum_o);
      end
      out_wait = idle_on ? $urandom_range(0, 17) : 0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    table_row_t rows[$];
    table_row_t row;
    count_rsp_t z;
    sample_req_t r;
    z = '{default: '0};
    lower_q = 0; upper_q = 65536; ax_q = 0; ay_q = 0; az_q = 16384; shift_q = 0;
    for (int i = 0; i < MOLECULES; i++) begin
      entry_t_q[i] = '0;
      entry_dir_q[i] = pcc_pkg::DIR_NONE;
    end
    for (int i = 0; i < HIST_BINS; i++) begin
      res_hist_q[i] = '0;
      cross_hist_q[i] = '0;
    end
    fup_q = '0; fdown_q = '0; fsum_q = '0; tup_q = '0; tdown_q = '0; tsum_q = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_geometry(0, 65536, 0, 0, 16384, 0);

    // directed table, defaults: planes at 0 and 1.0, axis +z
    row.lit = 1; row.e = z;
    row.r = mk_req(pcc_pkg::CMD_READ, 0, 0, 0, 0, 0); rows.push_back(row);
    row.r = mk_req(pcc_pkg::CMD_NOP, 0, 0, 0, 0, 0); rows.push_back(row);
    row.r = mk_req(pcc_pkg::CMD_READ, 0, 0, 0, 0, 1023); rows.push_back(row);
    // exit without entry
    row.r = mk_req(pcc_pkg::CMD_SAMPLE, 5, 100, 100000, 32768, 0);
    row.e = z; row.e.res_time = 100; rows.push_back(row);
    // up crossing of molecule 1
    row.r = mk_req(pcc_pkg::CMD_SAMPLE, 1, 110, 30000, -1000, 0); row.e = z; rows.push_back(row);
    row.r = mk_req(pcc_pkg::CMD_SAMPLE, 1, 130, 70000, 30000, 0);
    row.e = z; row.e.crossed = 1; row.e.cmol = 1; row.e.res_time = 20;
    row.e.fup = 1; row.e.fsum = 20; rows.push_back(row);
    row.r = mk_req(pcc_pkg::CMD_FRAME, 0, 130, 0, 0, 0);
    row.e = z; row.e.fup = 1; row.e.fsum = 20; row.e.tup = 1; row.e.tsum = 20;
    rows.push_back(row);
    row.r = mk_req(pcc_pkg::CMD_READ, 0, 130, 0, 0, 20);
    row.e = z; row.e.res_count = 1; row.e.cross_count = 1; row.e.tup = 1; row.e.tsum = 20;
    rows.push_back(row);
    // down crossing of molecule 2
    row.r = mk_req(pcc_pkg::CMD_SAMPLE, 2, 140, 30000, 70000, 0);
    row.e = z; row.e.tup = 1; row.e.tsum = 20; rows.push_back(row);
    row.r = mk_req(pcc_pkg::CMD_SAMPLE, 2, 150, -5, 30000, 0);
    row.e = z; row.e.crossed = 1; row.e.cmol = 2; row.e.res_time = 10;
    row.e.fdown = 1; row.e.fsum = 10; row.e.tup = 1; row.e.tsum = 20; rows.push_back(row);
    row.lit = 0;
    // time going backwards, direction mismatch
    row.r = mk_req(pcc_pkg::CMD_SAMPLE, 3, 1000, 30000, -1, 0); rows.push_back(row);
    row.r = mk_req(pcc_pkg::CMD_SAMPLE, 3, 500, -2, 30000, 0); rows.push_back(row);
    // long residence clamps to the last bin
    row.r = mk_req(pcc_pkg::CMD_SAMPLE, 4095, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 40000, 0);
    rows.push_back(row);
    // extreme coordinates
    r = mk_req(pcc_pkg::CMD_SAMPLE, 7, 2000, 1, 32'h8000_0000, 0);
    r.px = 32'h8000_0000; r.qx = 32'h7FFF_FFFF; r.py = 32'h7FFF_FFFF; r.qy = 32'h8000_0000;
    row.r = r; rows.push_back(row);
    r.t = 2500; r.pz = 32'h7FFF_FFFF; r.qz = 1;
    r.px = 32'h7FFF_FFFF; r.qx = 32'h8000_0000;
    row.r = r; rows.push_back(row);
    row.r = mk_req(pcc_pkg::CMD_READ, 0, 0, 0, 0, 1023); rows.push_back(row);
    row.r = mk_req(pcc_pkg::CMD_READ, 0, 0, 0, 0, 100); rows.push_back(row);
    row.r = mk_req(pcc_pkg::CMD_FRAME, 0, 0, 0, 0, 0); rows.push_back(row);
    row.r = mk_req(pcc_pkg::CMD_NOP, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   10'h3FF);
    rows.push_back(row);

    @(negedge clk_i);
    foreach (rows[i]) send_sample(rows[i].r, rows[i].lit, rows[i].e);
    clock_ticks = 3000;
    send_random(100);

    // wide pore, tilted axis, back-pressure burst
    in_valid_i = 1'b0;
    set_geometry(-300000, 500000, $urandom_range(0, 65535), $urandom_range(0, 65535),
                 -16384, 3);
    @(negedge clk_i);
    hold_go = 1'b1;
    send_random(300);

    // extreme registers: no plane can be crossed strictly
    in_valid_i = 1'b0;
    set_geometry(32'h8000_0000, 32'h7FFF_FFFF, -32768, 32767, -32768, 31);
    @(negedge clk_i);
    send_random(200);

    // narrow pore, no idling
    in_valid_i = 1'b0;
    set_geometry(1000, 1006, 32767, -32768, 32767, $urandom_range(0, 5));
    @(negedge clk_i);
    idle_on = 1'b0;
    send_random(250);

    in_valid_i = 1'b0;
    idle_on = 1'b1;
    set_geometry(-70000, 90000, $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom_range(0, 31));
    @(negedge clk_i);
    send_random(250);
    in_valid_i = 1'b0;

    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
